### hw/rtl/rudder_limit_calibration_defines.svh
// Assertion macros shared by the checker file of the rudder limit calibration block.
`ifndef RUDDER_LIMIT_CALIBRATION_DEFINES_SVH
`define RUDDER_LIMIT_CALIBRATION_DEFINES_SVH

// The antecedent and the consequent hold in the same cycle.
`define RLC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rlc_pkg.sv
package rlc_pkg;

  parameter int unsigned SampleBitsDef = 12;

  parameter int unsigned AngleBits = 15;
  parameter int unsigned MagBits   = 14;
  parameter int unsigned AngleMax  = 12868;

  parameter int unsigned BandBits  = 14;
  parameter int unsigned BandReset = 1638;

  parameter logic OpTick    = 1'b0;
  parameter logic OpRestore = 1'b1;

endpackage

### hw/rtl/rlc_in_if.sv
interface rlc_in_if #(
  parameter int unsigned SampleBits = rlc_pkg::SampleBitsDef
);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [SampleBits-1:0] pot_value;
  logic                  port_switch;
  logic                  star_switch;
  logic                  start_request;
  logic [SampleBits-1:0] saved_port;
  logic [SampleBits-1:0] saved_star;

  modport source (
    output valid, op, pot_value, port_switch, star_switch, start_request, saved_port,
           saved_star,
    input  ready
  );

  modport sink (
    input  valid, op, pot_value, port_switch, star_switch, start_request, saved_port,
           saved_star,
    output ready
  );
endinterface

### hw/rtl/rlc_out_if.sv
interface rlc_out_if #(
  parameter int unsigned SampleBits = rlc_pkg::SampleBitsDef
);
  logic                                valid;
  logic                                ready;
  logic signed [rlc_pkg::AngleBits-1:0] angle;
  logic                                motor_run;
  logic                                toward_port;
  logic                                is_calibrated;
  logic                                is_calibrating;
  logic [SampleBits-1:0]               port_reading;
  logic [SampleBits-1:0]               star_reading;
  logic                                save_pulse;

  modport source (
    output valid, angle, motor_run, toward_port, is_calibrated, is_calibrating,
           port_reading, star_reading, save_pulse,
    input  ready
  );

  modport sink (
    input  valid, angle, motor_run, toward_port, is_calibrated, is_calibrating,
           port_reading, star_reading, save_pulse,
    output ready
  );
endinterface

### hw/rtl/rudder_limit_calibration.sv
// Rudder limit calibration: each accepted word is a control tick or a restore of saved
// limits, and each gives exactly one result word with the rudder angle in signed Q1.14
// radians (saturated to 0.7854) and the calibration status. The angle is a rounded
// quotient worked out by one shared compare-subtract unit, one quotient bit per cycle, so
// a word with a nonzero limit span passes multiply, setup, 15 divider steps and update
// before the next ready; the divider stops after its first step when the quotient
// saturates, and a zero span goes from multiply straight to update. A pending result word
// does not block the next input word until that word's own result is due. The recentering
// band register may be written only while the block is idle; it resets to 1638 (0.1 rad).
module rudder_limit_calibration #(
  parameter int unsigned SampleBits = rlc_pkg::SampleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rlc_pkg::BandBits-1:0] cfg_wdata_i,
  rlc_in_if.sink                       item_i,
  rlc_out_if.source                    result_o
);

  localparam int unsigned ValW  = SampleBits + 1;
  localparam int unsigned DiffW = SampleBits + 3;
  localparam int unsigned ProdW = DiffW + rlc_pkg::AngleBits;
  localparam int unsigned RemW  = SampleBits + 18;
  localparam int unsigned MagW  = rlc_pkg::MagBits;
  localparam int unsigned AngW  = rlc_pkg::AngleBits;
  localparam int unsigned CntW  = $clog2(MagW + 1);

  localparam logic [MagW-1:0]        MagMax   = MagW'(rlc_pkg::AngleMax);
  localparam logic signed [AngW-1:0] AngMaxS  = AngW'(rlc_pkg::AngleMax);
  localparam logic [CntW-1:0]        CntFirst = CntW'(MagW);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StPrep,
    StDiv,
    StFin
  } state_e;

  typedef enum logic [2:0] {
    PhIdle       = 3'd0,
    PhInit       = 3'd1,
    PhFirstPort  = 3'd2,
    PhFirstStar  = 3'd3,
    PhSecondPort = 3'd4,
    PhSecondStar = 3'd5,
    PhRecenter   = 3'd6
  } phase_e;

  state_e                  state_q;
  phase_e                  phase_q, phase_d;
  logic [rlc_pkg::BandBits-1:0] band_q;
  logic [SampleBits-1:0]   port_q, port_d;
  logic [SampleBits-1:0]   star_q, star_d;
  logic                    calibrated_q, calibrated_d;
  logic                    calibrating_q, calibrating_d;
  logic                    run_q, run_d;
  logic                    dir_q, dir_d;
  logic                    save_d;

  logic                    op_q;
  logic [SampleBits-1:0]   pot_q;
  logic                    port_sw_q;
  logic                    star_sw_q;
  logic                    start_q;

  logic signed [ProdW-1:0] prod_q;
  logic signed [ValW-1:0]  span_q;
  logic [RemW-1:0]         rem_q;
  logic [RemW-1:0]         dsh_q;
  logic [MagW-1:0]         quo_q;
  logic [CntW-1:0]         cnt_q;
  logic                    sat_q;
  logic                    neg_q;

  logic                    out_valid_q;
  logic signed [AngW-1:0]  res_angle_q;
  logic                    res_run_q;
  logic                    res_dir_q;
  logic                    res_calibrated_q;
  logic                    res_calibrating_q;
  logic [SampleBits-1:0]   res_port_q;
  logic [SampleBits-1:0]   res_star_q;
  logic                    res_save_q;

  logic signed [ValW-1:0]  val_w;
  logic signed [ValW-1:0]  span_w;
  logic signed [DiffW-1:0] diff_w;
  logic signed [ProdW-1:0] diff_x;
  logic signed [ProdW-1:0] prod_w;
  logic [ProdW-1:0]        an_w;
  logic [ValW-1:0]         as_w;
  logic                    ge_w;
  logic [MagW-1:0]         mag_w;
  logic signed [AngW-1:0]  angle_w;
  logic                    out_free_w;
  logic                    out_set_w;
  logic                    in_acc_w;

  assign in_acc_w   = item_i.valid && (state_q == StIdle);
  assign out_free_w = !out_valid_q || result_o.ready;
  assign out_set_w  = (state_q == StFin) && out_free_w;

  always_comb begin
    val_w  = $signed({1'b0, pot_q}) - $signed({1'b0, port_q});
    span_w = $signed({1'b0, star_q}) - $signed({1'b0, port_q});
    diff_w = DiffW'(span_w) - (DiffW'(val_w) <<< 1);
    diff_x = ProdW'(diff_w);
    prod_w = diff_x * ProdW'(AngMaxS);
    an_w   = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
    as_w   = span_q[ValW-1] ? ValW'(-span_q) : ValW'(span_q);
    ge_w   = rem_q >= dsh_q;
    if (sat_q || (quo_q > MagMax)) begin
      mag_w = MagMax;
    end else begin
      mag_w = quo_q;
    end
    angle_w = neg_q ? -$signed({1'b0, mag_w}) : $signed({1'b0, mag_w});
  end

  // Calibration sequencer step, evaluated with the angle of the current word.
  always_comb begin
    phase_d       = phase_q;
    port_d        = port_q;
    star_d        = star_q;
    calibrated_d  = calibrated_q;
    calibrating_d = calibrating_q;
    run_d         = run_q;
    dir_d         = dir_q;
    save_d        = 1'b0;
    if (op_q == rlc_pkg::OpTick) begin
      if (start_q && !calibrating_q) begin
        phase_d = PhInit;
      end
      case (phase_d)
        PhInit: begin
          calibrated_d  = 1'b0;
          calibrating_d = 1'b1;
          run_d         = 1'b1;
          port_d        = '0;
          star_d        = '0;
          if (star_sw_q) begin
            phase_d = PhFirstPort;
            dir_d   = 1'b1;
          end else begin
            phase_d = PhFirstStar;
            dir_d   = 1'b0;
          end
        end
        PhFirstPort: begin
          if (port_sw_q) begin
            port_d  = pot_q;
            phase_d = PhSecondStar;
            dir_d   = 1'b0;
          end
        end
        PhFirstStar: begin
          if (star_sw_q) begin
            star_d  = pot_q;
            phase_d = PhSecondPort;
            dir_d   = 1'b1;
          end
        end
        PhSecondPort: begin
          if (port_sw_q) begin
            port_d       = pot_q;
            save_d       = 1'b1;
            phase_d      = PhRecenter;
            dir_d        = 1'b0;
            calibrated_d = 1'b1;
          end
        end
        PhSecondStar: begin
          if (star_sw_q) begin
            star_d       = pot_q;
            save_d       = 1'b1;
            phase_d      = PhRecenter;
            dir_d        = 1'b1;
            calibrated_d = 1'b1;
          end
        end
        PhRecenter: begin
          if (mag_w < band_q) begin
            run_d         = 1'b0;
            calibrating_d = 1'b0;
            phase_d       = PhIdle;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= StIdle;
      phase_q           <= PhIdle;
      band_q            <= rlc_pkg::BandBits'(rlc_pkg::BandReset);
      port_q            <= '0;
      star_q            <= '0;
      calibrated_q      <= 1'b0;
      calibrating_q     <= 1'b0;
      run_q             <= 1'b0;
      dir_q             <= 1'b0;
      out_valid_q       <= 1'b0;
      op_q              <= rlc_pkg::OpTick;
      pot_q             <= '0;
      port_sw_q         <= 1'b0;
      star_sw_q         <= 1'b0;
      start_q           <= 1'b0;
      prod_q            <= '0;
      span_q            <= '0;
      rem_q             <= '0;
      dsh_q             <= '0;
      quo_q             <= '0;
      cnt_q             <= '0;
      sat_q             <= 1'b0;
      neg_q             <= 1'b0;
      res_angle_q       <= '0;
      res_run_q         <= 1'b0;
      res_dir_q         <= 1'b0;
      res_calibrated_q  <= 1'b0;
      res_calibrating_q <= 1'b0;
      res_port_q        <= '0;
      res_star_q        <= '0;
      res_save_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        band_q <= cfg_wdata_i;
      end
      if (out_set_w) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc_w) begin
            op_q      <= item_i.op;
            pot_q     <= item_i.pot_value;
            port_sw_q <= item_i.port_switch;
            star_sw_q <= item_i.star_switch;
            start_q   <= item_i.start_request;
            if ((item_i.op == rlc_pkg::OpRestore) && !calibrating_q) begin
              port_q       <= item_i.saved_port;
              star_q       <= item_i.saved_star;
              calibrated_q <= 1'b1;
            end
            state_q <= StMul;
          end
        end
        StMul: begin
          prod_q <= prod_w;
          span_q <= span_w;
          quo_q  <= '0;
          sat_q  <= (span_w == '0) && (val_w != '0);
          if (span_w == '0) begin
            neg_q   <= (val_w > 0);
            state_q <= StFin;
          end else begin
            state_q <= StPrep;
          end
        end
        StPrep: begin
          rem_q   <= (RemW'(an_w) << 1) + RemW'(as_w);
          dsh_q   <= RemW'(as_w) << (MagW + 1);
          neg_q   <= prod_q[ProdW-1] != span_q[ValW-1];
          cnt_q   <= CntFirst;
          state_q <= StDiv;
        end
        StDiv: begin
          if ((cnt_q == CntFirst) && ge_w) begin
            sat_q   <= 1'b1;
            state_q <= StFin;
          end else begin
            if (ge_w) begin
              rem_q <= rem_q - dsh_q;
            end
            quo_q <= {quo_q[MagW-2:0], ge_w};
            dsh_q <= dsh_q >> 1;
            if (cnt_q == '0) begin
              state_q <= StFin;
            end else begin
              cnt_q <= cnt_q - CntW'(1);
            end
          end
        end
        StFin: begin
          if (out_free_w) begin
            phase_q           <= phase_d;
            port_q            <= port_d;
            star_q            <= star_d;
            calibrated_q      <= calibrated_d;
            calibrating_q     <= calibrating_d;
            run_q             <= run_d;
            dir_q             <= dir_d;
            res_angle_q       <= angle_w;
            res_run_q         <= run_d;
            res_dir_q         <= dir_d;
            res_calibrated_q  <= calibrated_d;
            res_calibrating_q <= calibrating_d;
            res_port_q        <= port_d;
            res_star_q        <= star_d;
            res_save_q        <= save_d;
            state_q           <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign item_i.ready            = (state_q == StIdle);
  assign result_o.valid          = out_valid_q;
  assign result_o.angle          = res_angle_q;
  assign result_o.motor_run      = res_run_q;
  assign result_o.toward_port    = res_dir_q;
  assign result_o.is_calibrated  = res_calibrated_q;
  assign result_o.is_calibrating = res_calibrating_q;
  assign result_o.port_reading   = res_port_q;
  assign result_o.star_reading   = res_star_q;
  assign result_o.save_pulse     = res_save_q;

endmodule

### hw/rtl/rlc_checker.sv
`include "rudder_limit_calibration_defines.svh"

module rlc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [rlc_pkg::AngleBits-1:0] angle_i,
  input logic                                motor_run_i,
  input logic                                is_calibrated_i,
  input logic                                is_calibrating_i,
  input logic                                save_pulse_i
);

  localparam logic signed [rlc_pkg::AngleBits-1:0] AngMax =
    rlc_pkg::AngleBits'(rlc_pkg::AngleMax);

  `RLC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i,
    "input accepted while a word is in work")

  `RLC_ASSERT_SAME(a_angle_range, out_valid_i, (angle_i <= AngMax) && (angle_i >= -AngMax),
    "angle outside the saturation range")

  `RLC_ASSERT_SAME(a_save_state, out_valid_i && save_pulse_i,
    is_calibrated_i && is_calibrating_i && motor_run_i,
    "save requested outside the calibration sequence")

  `RLC_ASSERT_SAME(a_motor_idle, out_valid_i && !is_calibrating_i, !motor_run_i,
    "motor runs while no calibration is in progress")

  `RLC_ASSERT_NEXT(a_result_held, out_valid_i && !out_ready_i,
    out_valid_i && $stable(angle_i),
    "stalled result word changed")

endmodule

bind rudder_limit_calibration rlc_checker u_rlc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (item_i.valid),
  .in_ready_i       (item_i.ready),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .angle_i          (result_o.angle),
  .motor_run_i      (result_o.motor_run),
  .is_calibrated_i  (result_o.is_calibrated),
  .is_calibrating_i (result_o.is_calibrating),
  .save_pulse_i     (result_o.save_pulse)
);
